FILE: sv/swm_pkg.sv
// Shared types and constants for the sliding-window median absolute cost unit.
// No dependencies; every other file refers to it by scoped names.
package swm_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 30;
  localparam int COST_BITS   = 38;
  localparam int WSIZE_BITS  = 9;
  localparam int PTR_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int TAP_GROUP   = 16;
  localparam int TAP_GROUPS  = (WINDOW_MAX + TAP_GROUP - 1) / TAP_GROUP;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COST_BITS-1:0]   cost_t;
  typedef logic [WSIZE_BITS-1:0]  wsize_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // Operation broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    sample_t  key;
  } cell_ctl_t;

  // Where a cell stands relative to the fill count
  typedef struct packed {
    logic occ;   // cell holds a live entry
    logic tail;  // first free cell
  } cell_pos_t;

endpackage

FILE: sv/swm_ifs.sv
// Valid/ready channel interfaces for samples, costs and the window size write.
// Depends on swm_pkg for payload types.
interface swm_sample_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_cost_if;
  logic           valid;
  logic           ready;
  swm_pkg::cost_t cost;
  modport source (output valid, output cost, input ready);
  modport sink (input valid, input cost, output ready);
endinterface

interface swm_cfg_if;
  logic            valid;
  logic            ready;
  swm_pkg::wsize_t window_size;
  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

FILE: sv/swm_cell.sv
// One cell of the sorted chain: holds one sorted entry and shifts it
// toward a neighbor on remove or insert. Depends on swm_pkg.
module swm_cell (
  input  logic               clk,
  input  swm_pkg::cell_ctl_t ctl,
  input  swm_pkg::cell_pos_t pos,
  input  swm_pkg::sample_t   left_val,
  input  logic               left_flag,
  input  swm_pkg::sample_t   right_val,
  output swm_pkg::sample_t   val,
  output logic               flag
);

  swm_pkg::sample_t val_next;

  // Compare against the key and pick the neighbor to take from
  always_comb begin
    flag     = 1'b0;
    val_next = val;
    unique case (ctl.op)
      swm_pkg::CELL_REMOVE: begin
        // first entry at or above the key and all above it move down
        flag = pos.occ && (val >= ctl.key);
        if (flag) begin
          val_next = right_val;
        end
      end
      swm_pkg::CELL_INSERT: begin
        // entries above the key move up; the slot at the boundary takes the key
        flag = pos.occ && (val > ctl.key);
        if (flag || pos.tail) begin
          val_next = left_flag ? left_val : ctl.key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: sv/swm_tap.sv
// Two-level registered select that reads two chosen cells of the chain.
// Both group and output results are registered. Depends on swm_pkg.
module swm_tap (
  input  logic             clk,
  input  swm_pkg::sample_t vals [swm_pkg::WINDOW_MAX],
  input  swm_pkg::ptr_t    sel_lo,
  input  swm_pkg::ptr_t    sel_hi,
  output swm_pkg::sample_t lo,
  output swm_pkg::sample_t hi
);

  swm_pkg::sample_t grp_lo      [swm_pkg::TAP_GROUPS];
  swm_pkg::sample_t grp_hi      [swm_pkg::TAP_GROUPS];
  swm_pkg::sample_t grp_lo_next [swm_pkg::TAP_GROUPS];
  swm_pkg::sample_t grp_hi_next [swm_pkg::TAP_GROUPS];
  swm_pkg::sample_t lo_next;
  swm_pkg::sample_t hi_next;

  // First level: mask and merge within each group
  always_comb begin
    for (int g = 0; g < swm_pkg::TAP_GROUPS; g++) begin
      grp_lo_next[g] = '0;
      grp_hi_next[g] = '0;
      for (int j = 0; j < swm_pkg::TAP_GROUP; j++) begin
        if (g * swm_pkg::TAP_GROUP + j < swm_pkg::WINDOW_MAX) begin
          if (swm_pkg::ptr_t'(g * swm_pkg::TAP_GROUP + j) == sel_lo) begin
            grp_lo_next[g] = grp_lo_next[g] | vals[g * swm_pkg::TAP_GROUP + j];
          end
          if (swm_pkg::ptr_t'(g * swm_pkg::TAP_GROUP + j) == sel_hi) begin
            grp_hi_next[g] = grp_hi_next[g] | vals[g * swm_pkg::TAP_GROUP + j];
          end
        end
      end
    end
  end

  // Second level: merge the group results
  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int g = 0; g < swm_pkg::TAP_GROUPS; g++) begin
      lo_next = lo_next | grp_lo[g];
      hi_next = hi_next | grp_hi[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_lo <= grp_lo_next;
    grp_hi <= grp_hi_next;
    lo     <= lo_next;
    hi     <= hi_next;
  end

endmodule

FILE: sv/sliding_window_median_abs_cost_unit.sv
// Sliding-window median absolute cost unit. A sample that completes no window
// passes ST_RWAIT, ST_REMOVE, ST_IWAIT1, ST_IWAIT2 and ST_INSERT before the
// next ready, one that yields a cost also ST_MWAIT1, ST_MWAIT2, ST_MULT and
// ST_COST (plus any wait for the cost output to drain). The sorted cell chain
// removes the evicted sample and inserts the new one, and the median tap must
// see the chain settle after each update. The first window_size-1 samples
// after reset or after a window_size write give no cost. Window sizes of zero
// read as one and sizes above 256 read as 256. A window_size write is taken
// only while the unit is idle, and samples are held off in the cycle it is
// offered. No clearing pass after reset.
// Depends on swm_pkg, swm_ifs, swm_cell and swm_tap.
module sliding_window_median_abs_cost_unit (
  input logic                clk,
  input logic                rst,
  swm_sample_if.sink         sample_in,
  swm_cost_if.source         cost_out,
  swm_cfg_if.sink            cfg
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RWAIT,
    ST_REMOVE,
    ST_IWAIT1,
    ST_IWAIT2,
    ST_INSERT,
    ST_MWAIT1,
    ST_MWAIT2,
    ST_MULT,
    ST_COST
  } state_t;

  localparam int PROD_BITS = swm_pkg::SAMPLE_BITS + swm_pkg::CNT_BITS;

  state_t           state;
  swm_pkg::cnt_t    cnt;
  swm_pkg::cnt_t    k_reg;
  swm_pkg::cnt_t    m_reg;
  swm_pkg::cnt_t    km_reg;
  swm_pkg::ptr_t    rp;
  swm_pkg::cost_t   lower_sum;
  swm_pkg::cost_t   upper_sum;
  logic             full;
  logic             out_valid;

  swm_pkg::sample_t ring [swm_pkg::WINDOW_MAX];
  swm_pkg::sample_t s_reg;
  swm_pkg::sample_t old_val;
  swm_pkg::cost_t   prod_a;
  swm_pkg::cost_t   prod_b;
  swm_pkg::cost_t   out_cost;

  swm_pkg::sample_t  cell_val  [swm_pkg::WINDOW_MAX];
  logic              cell_flag [swm_pkg::WINDOW_MAX];
  swm_pkg::cell_ctl_t cell_ctl;
  swm_pkg::sample_t  tap_lo;
  swm_pkg::sample_t  tap_hi;

  logic             accept;
  logic             cfg_write;
  logic             load_out;
  swm_pkg::ptr_t    rp_next;
  swm_pkg::ptr_t    old_ptr;
  swm_pkg::cnt_t    k_new;
  logic [swm_pkg::CNT_BITS:0] k_inc;
  swm_pkg::cnt_t    m_new;
  logic             lo_occ;
  logic             hi_occ;
  logic             r_lt_m;
  logic             p_lt_m;
  swm_pkg::cnt_t    cnt_inc;
  logic             emit_now;
  swm_pkg::cost_t   s_ext;
  swm_pkg::cost_t   old_ext;
  swm_pkg::cost_t   lo_ext;
  swm_pkg::cost_t   hi_ext;
  swm_pkg::cost_t   rem_lower;
  swm_pkg::cost_t   rem_upper;
  swm_pkg::cost_t   ins_lower;
  swm_pkg::cost_t   ins_upper;
  swm_pkg::cost_t   cost_val;
  logic [PROD_BITS-1:0] pa;
  logic [PROD_BITS-1:0] pb;

  // Handshakes: a window_size write wins over a sample in the idle state
  assign sample_in.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready       = (state == ST_IDLE);
  assign accept          = sample_in.valid && sample_in.ready;
  assign cfg_write       = cfg.valid && cfg.ready;
  assign load_out        = (state == ST_COST) && (!out_valid || cost_out.ready);
  assign cost_out.valid  = out_valid;
  assign cost_out.cost   = out_cost;

  // Ring addressing: write at the pointer, read the sample k transfers back
  assign rp_next = (rp == swm_pkg::ptr_t'(swm_pkg::WINDOW_MAX - 1)) ? '0 : rp + 1'b1;
  always_comb begin
    if ({1'b0, rp} >= swm_pkg::CNT_BITS'(k_reg)) begin
      old_ptr = swm_pkg::ptr_t'({1'b0, rp} - k_reg);
    end else begin
      old_ptr = swm_pkg::ptr_t'({1'b0, rp} + swm_pkg::cnt_t'(swm_pkg::WINDOW_MAX) - k_reg);
    end
  end

  // Saturate the written window size and derive the lower-part length
  always_comb begin
    if (cfg.window_size == '0) begin
      k_new = swm_pkg::cnt_t'(1);
    end else if (cfg.window_size > swm_pkg::WSIZE_BITS'(swm_pkg::WINDOW_MAX)) begin
      k_new = swm_pkg::cnt_t'(swm_pkg::WINDOW_MAX);
    end else begin
      k_new = swm_pkg::cnt_t'(cfg.window_size);
    end
  end
  assign k_inc = {1'b0, k_new} + 1'b1;
  assign m_new = k_inc[swm_pkg::CNT_BITS:1];

  // Drive the chain
  always_comb begin
    cell_ctl.op  = swm_pkg::CELL_HOLD;
    cell_ctl.key = s_reg;
    if (state == ST_REMOVE && full) begin
      cell_ctl.op  = swm_pkg::CELL_REMOVE;
      cell_ctl.key = old_val;
    end else if (state == ST_INSERT) begin
      cell_ctl.op  = swm_pkg::CELL_INSERT;
    end
  end

  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    swm_pkg::cell_pos_t pos;
    swm_pkg::sample_t   left_val;
    logic               left_flag;
    swm_pkg::sample_t   right_val;

    assign pos.occ  = swm_pkg::cnt_t'(i) < cnt;
    assign pos.tail = swm_pkg::cnt_t'(i) == cnt;
    if (i == 0) begin : g_first
      assign left_val  = '0;
      assign left_flag = 1'b0;
    end else begin : g_mid
      assign left_val  = cell_val[i-1];
      assign left_flag = cell_flag[i-1];
    end
    if (i == swm_pkg::WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .pos       (pos),
      .left_val  (left_val),
      .left_flag (left_flag),
      .right_val (right_val),
      .val       (cell_val[i]),
      .flag      (cell_flag[i])
    );
  end

  // Read the median cell and the one above it
  swm_tap u_tap (
    .clk    (clk),
    .vals   (cell_val),
    .sel_lo (swm_pkg::ptr_t'(m_reg - 1'b1)),
    .sel_hi (swm_pkg::ptr_t'(m_reg)),
    .lo     (tap_lo),
    .hi     (tap_hi)
  );

  // Keep the lower and upper sums in step with the chain
  assign lo_occ  = (m_reg - 1'b1) < cnt;
  assign hi_occ  = m_reg < cnt;
  assign s_ext   = swm_pkg::cost_t'(s_reg);
  assign old_ext = swm_pkg::cost_t'(old_val);
  assign lo_ext  = swm_pkg::cost_t'(tap_lo);
  assign hi_ext  = hi_occ ? swm_pkg::cost_t'(tap_hi) : '0;
  assign r_lt_m  = lo_occ && (tap_lo >= old_val);
  assign p_lt_m  = !lo_occ || (tap_lo > s_reg);
  assign cnt_inc = cnt + 1'b1;
  assign emit_now = (cnt_inc == k_reg);

  always_comb begin
    if (r_lt_m) begin
      rem_lower = lower_sum - old_ext + hi_ext;
      rem_upper = upper_sum - hi_ext;
    end else begin
      rem_lower = lower_sum;
      rem_upper = upper_sum - old_ext;
    end
    if (p_lt_m) begin
      ins_lower = lower_sum + s_ext - (lo_occ ? lo_ext : '0);
      ins_upper = upper_sum + (lo_occ ? lo_ext : '0);
    end else begin
      ins_lower = lower_sum;
      ins_upper = upper_sum + s_ext;
    end
  end

  // Cost from the median: med*m - lower + upper - med*(k-m)
  assign pa       = tap_lo * m_reg;
  assign pb       = tap_lo * km_reg;
  assign cost_val = prod_a - lower_sum + upper_sum - prod_b;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      k_reg     <= swm_pkg::cnt_t'(1);
      m_reg     <= swm_pkg::cnt_t'(1);
      km_reg    <= '0;
      rp        <= '0;
      lower_sum <= '0;
      upper_sum <= '0;
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // present a new cost, or drop the current one once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (cost_out.ready) begin
        out_valid <= 1'b0;
      end
      // window size write restarts filling
      if (cfg_write) begin
        k_reg     <= k_new;
        m_reg     <= m_new;
        km_reg    <= k_new - m_new;
        cnt       <= '0;
        lower_sum <= '0;
        upper_sum <= '0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (accept) begin
              full  <= (cnt == k_reg);
              rp    <= rp_next;
              state <= ST_RWAIT;
            end
          end
          ST_RWAIT: state <= ST_REMOVE;
          ST_REMOVE: begin
            if (full) begin
              cnt       <= cnt - 1'b1;
              lower_sum <= rem_lower;
              upper_sum <= rem_upper;
            end
            state <= ST_IWAIT1;
          end
          ST_IWAIT1: state <= ST_IWAIT2;
          ST_IWAIT2: state <= ST_INSERT;
          ST_INSERT: begin
            cnt       <= cnt_inc;
            lower_sum <= ins_lower;
            upper_sum <= ins_upper;
            state     <= emit_now ? ST_MWAIT1 : ST_IDLE;
          end
          ST_MWAIT1: state <= ST_MWAIT2;
          ST_MWAIT2: state <= ST_MULT;
          ST_MULT:   state <= ST_COST;
          ST_COST: begin
            if (load_out) begin
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Payload: ring memory, captured sample, products, cost
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[rp] <= sample_in.sample;
      old_val  <= ring[old_ptr];
      s_reg    <= sample_in.sample;
    end
    if (state == ST_MULT) begin
      prod_a <= swm_pkg::cost_t'(pa);
      prod_b <= swm_pkg::cost_t'(pb);
    end
    if (load_out) begin
      out_cost <= cost_val;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst) cnt <= k_reg)
    else $error("fill count above window size");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REMOVE && full && !cfg.valid) |=> cnt == $past(cnt) - 1'b1)
    else $error("eviction did not shrink the sorted chain");

  a_full_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT && full && !cfg.valid) |=> state == ST_MWAIT1)
    else $error("full window did not produce a cost");

  a_out_from_cost: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_COST)
    else $error("cost presented outside the cost step");

endmodule

FILE: tb/sv/swm_cost_scoreboard_pkg.sv
// Scoreboard for the sliding-window median absolute cost unit: predicts each cost
// from the accepted samples and checks the costs that come out. Depends on swm_pkg.
package swm_cost_scoreboard_pkg;

  class median_cost_scoreboard;
    swm_pkg::sample_t arrival[swm_pkg::WINDOW_MAX];  // samples in arrival order
    swm_pkg::sample_t ordered[swm_pkg::WINDOW_MAX];  // live samples, ascending
    int unsigned      wr_ptr;
    int unsigned      filled;
    swm_pkg::wsize_t  win_len;              // raw register value
    swm_pkg::cost_t   pending_costs[$];
    int unsigned      n_samples;
    int unsigned      n_costs;
    int unsigned      n_writes;
    int unsigned      n_errors;

    function new();
      wr_ptr    = 0;
      filled    = 0;
      win_len   = 1;
      n_samples = 0;
      n_costs   = 0;
      n_writes  = 0;
      n_errors  = 0;
    endfunction

    // Zero reads as one, anything past the ring depth saturates
    function int unsigned window_span();
      if (win_len == 0) return 1;
      if (win_len > swm_pkg::WINDOW_MAX) return swm_pkg::WINDOW_MAX;
      return win_len;
    endfunction

    // Register write: restart filling from the current ring position
    function void note_window(swm_pkg::wsize_t v);
      win_len = v;
      filled  = 0;
      n_writes++;
    endfunction

    // Accepted sample: evict, insert, and queue the cost once the window is full
    function void take_sample(swm_pkg::sample_t s);
      int unsigned k, m, old, i, j;
      bit [63:0]   lo, hi, med, c;
      k = window_span();
      n_samples++;
      if (filled == k) begin
        old = (wr_ptr + swm_pkg::WINDOW_MAX - k) % swm_pkg::WINDOW_MAX;
        i = 0;
        while (i < filled && ordered[i] != arrival[old]) i++;
        if (i < filled) begin
          for (j = i; j + 1 < filled; j++) ordered[j] = ordered[j + 1];
          filled--;
        end
      end
      // shift larger entries up and drop the new one in
      i = filled;
      while (i > 0 && ordered[i - 1] > s) begin
        ordered[i] = ordered[i - 1];
        i--;
      end
      ordered[i] = s;
      filled++;
      arrival[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % swm_pkg::WINDOW_MAX;
      if (filled < k) return;
      // lower part holds the first (k+1)/2 entries, the median is its top
      m  = (k + 1) / 2;
      lo = 0;
      hi = 0;
      for (i = 0; i < k; i++) begin
        if (i < m) lo += ordered[i];
        else hi += ordered[i];
      end
      med = ordered[m - 1];
      c = med * m - lo + hi - med * (k - m);
      pending_costs = {pending_costs, swm_pkg::cost_t'(c)};
    endfunction

    function void check_cost(swm_pkg::cost_t got);
      swm_pkg::cost_t want;
      if (pending_costs.size() == 0) begin
        n_errors++;
        $error("cost: unexpected transfer, expected none, actual %0d", got);
        return;
      end
      want = pending_costs.pop_front();
      n_costs++;
      if (got !== want) begin
        n_errors++;
        $error("cost mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int unsigned pending();
      return pending_costs.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/sliding_window_median_abs_cost_unit_tb.sv
// Testbench for sliding_window_median_abs_cost_unit: directed and random samples
// over many window sizes, with random idling and back-pressure on both channels.
// Depends on swm_pkg, swm_ifs, swm_cost_scoreboard_pkg and the RTL.
module sliding_window_median_abs_cost_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      RANDOM_ITEMS  = 1650;
  localparam int unsigned      SETTLE_CYCLES = 24;
  localparam int unsigned      HOLD_CYCLES   = 400;
  localparam int unsigned      CYCLE_LIMIT   = 600000;
  localparam int unsigned      NUM_FIXED     = 7;
  localparam swm_pkg::sample_t SAMPLE_MAX    = '1;

  typedef enum int unsigned {
    MIX_FULL_RANGE,
    MIX_FEW_VALUES,
    MIX_EXTREMES,
    MIX_NARROW_BAND
  } sample_mix_t;

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_go;
  int unsigned cycle_count = 0;
  swm_cost_scoreboard_pkg::median_cost_scoreboard sb;

  swm_sample_if sample_bus();
  swm_cost_if   cost_bus();
  swm_cfg_if    cfg_bus();

  sliding_window_median_abs_cost_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_bus),
    .cost_out  (cost_bus),
    .cfg       (cfg_bus)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every cost transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && cost_bus.valid && cost_bus.ready) sb.check_cost(cost_bus.cost);
  end

  // Cost receiver: random stalls, one long hold-off when asked
  initial begin : cost_sink
    int unsigned hold_left;
    bit          hold_spent;
    hold_left      = 0;
    hold_spent     = 1'b0;
    cost_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        cost_bus.ready <= 1'b0;
      end else if (hold_go && !hold_spent) begin
        hold_spent = 1'b1;
        hold_left  = HOLD_CYCLES;
        cost_bus.ready <= 1'b0;
      end else begin
        cost_bus.ready <= no_idle || ($urandom_range(99) >= 14);
      end
    end
  end

  // Offer one sample, idling at random first, and return at its transfer edge
  task automatic send_sample(input swm_pkg::sample_t s);
    if (!no_idle) begin
      while ($urandom_range(99) < 14) begin
        sample_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    sb.take_sample(s);
  endtask

  // Drop valid and hold until every predicted cost has come out
  task automatic idle_until_drained();
    sample_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  // Write window_size once the block is idle
  task automatic write_window(input swm_pkg::wsize_t v);
    idle_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.window_size <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    sb.note_window(v);
  endtask

  function automatic swm_pkg::sample_t pick_sample(input sample_mix_t mix,
                                                   input swm_pkg::sample_t base);
    case (mix)
      MIX_FULL_RANGE: return swm_pkg::sample_t'($urandom);
      MIX_FEW_VALUES: return swm_pkg::sample_t'($urandom_range(7));
      MIX_EXTREMES: begin
        case ($urandom_range(2))
          0: return '0;
          1: return SAMPLE_MAX;
          default: return swm_pkg::sample_t'($urandom);
        endcase
      end
      default: return base + swm_pkg::sample_t'($urandom_range(15));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned      fixed_sizes[NUM_FIXED];
    swm_pkg::wsize_t  wsize;
    int unsigned      phase, n_items, sent, n;
    sample_mix_t      mix;
    swm_pkg::sample_t base;
    fixed_sizes = '{2, 511, 1, 0, 5, 256, 3};
    sb = new();
    rst                 = 1'b1;
    no_idle             = 1'b0;
    hold_go             = 1'b0;
    sample_bus.valid    = 1'b0;
    sample_bus.sample   = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.window_size = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Window of one from reset: every sample costs zero
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(30'h2AAAAAAA);
    send_sample(30'h15555555);
    // Size zero reads as one
    write_window(9'd0);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    // Even window: lower median, duplicates evicted
    write_window(9'd4);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
    send_sample(30'd7);
    send_sample(30'd7);
    send_sample(30'd7);
    // Odd window with extremes on both sides of the median
    write_window(9'd3);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(30'd1);
    send_sample(30'd1);
    send_sample(30'd1);

    // Random phases: fixed extremes first, then mostly small windows
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < NUM_FIXED) wsize = swm_pkg::wsize_t'(fixed_sizes[phase]);
      else if ($urandom_range(11) == 0) wsize = swm_pkg::wsize_t'($urandom_range(511));
      else wsize = swm_pkg::wsize_t'($urandom_range(1, 24));
      write_window(wsize);
      n_items = sb.window_span() - 1 + $urandom_range(15, 60);
      mix     = sample_mix_t'($urandom_range(3));
      base    = swm_pkg::sample_t'($urandom);
      no_idle <= (phase == 1);
      // window of one: every sample yields a cost while the receiver holds off
      if (phase == 2) hold_go <= 1'b1;
      for (n = 0; n < n_items; n++) begin
        if (phase == 4 && n == n_items / 2) idle_until_drained();
        send_sample(pick_sample(mix, base));
        sent++;
      end
      phase++;
    end

    idle_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d checked costs over %0d window_size writes,",
             sb.n_samples, sb.n_costs, sb.n_writes);
    $display("including zero, one and saturating sizes, a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sliding_window_median_abs_cost_unit.f
sv/swm_pkg.sv
sv/swm_ifs.sv
sv/swm_cell.sv
sv/swm_tap.sv
sv/sliding_window_median_abs_cost_unit.sv
tb/sv/swm_cost_scoreboard_pkg.sv
tb/sv/sliding_window_median_abs_cost_unit_tb.sv
